[hw/rtl/manchester_frame_encoder_assert.svh]
// Assertion macros shared by the Manchester frame encoder RTL.
// No dependencies; included by modules that check their own logic.
`ifndef MANCHESTER_FRAME_ENCODER_ASSERT_SVH
`define MANCHESTER_FRAME_ENCODER_ASSERT_SVH

// Property must hold at every rising clock edge outside reset.
`define MFE_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("manchester_frame_encoder: check failed");

// Expression must never be true outside reset.
`define MFE_NEVER(label, clk, rstn, expr) \
    `MFE_ASSERT(label, clk, rstn, !(expr))

`endif

[hw/rtl/mfe_pkg.sv]
// Package for the Manchester frame encoder: constants, byte codes and types.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package mfe_pkg;

    localparam int PREAMBLE_BYTES_DEF = 3;
    localparam int QUEUE_DEPTH_DEF    = 2;

    localparam logic [7:0] SYNC_BYTE  = 8'hAA;
    localparam logic [7:0] START_BYTE = 8'hAB;
    localparam logic [7:0] TAIL_BYTE  = 8'hAF;

    localparam logic [2:0] MSB_IDX = 3'd7;

    typedef enum logic [1:0] {
        PH_PREAMBLE,
        PH_START,
        PH_DATA,
        PH_TAIL
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        phase_t     start_phase;
        logic       has_tail;
    } desc_t;

endpackage

`default_nettype wire

[hw/rtl/mfe_front.sv]
// Front stage: takes input transfers and classifies them into job descriptors.
// Depends on mfe_pkg.
`default_nettype none

module mfe_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    in_data,
    input  wire logic          in_first,
    input  wire logic          in_last,
    output logic               out_valid,
    input  wire logic          out_ready,
    output mfe_pkg::desc_t     out_desc
);

    logic           valid_reg;
    logic           valid_next;
    mfe_pkg::desc_t desc_reg;
    mfe_pkg::desc_t desc_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_desc  = desc_reg;

    always_comb begin
        valid_next = valid_reg;
        desc_next  = desc_reg;
        if (in_valid && in_ready) begin
            valid_next            = 1'b1;
            desc_next.data        = in_data;
            desc_next.start_phase = in_first ? mfe_pkg::PH_PREAMBLE : mfe_pkg::PH_DATA;
            desc_next.has_tail    = in_last;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        desc_reg <= desc_next;
    end

endmodule

`default_nettype wire

[hw/rtl/mfe_queue.sv]
// Short descriptor queue between the front and back stages.
// Depends on mfe_pkg and manchester_frame_encoder_assert.svh.
`default_nettype none

`include "manchester_frame_encoder_assert.svh"

module mfe_queue #(
    parameter int DEPTH = mfe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire mfe_pkg::desc_t push_desc,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output mfe_pkg::desc_t      pop_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    mfe_pkg::desc_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_desc   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

    `MFE_NEVER(a_count_bound, aclk, aresetn, count_reg > FULL_CNT)
    `MFE_ASSERT(a_grow, aclk, aresetn, push && !pop |=> count_reg == $past(count_reg) + 1'b1)
    `MFE_ASSERT(a_ptr_gap, aclk, aresetn, count_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)

endmodule

`default_nettype wire

[hw/rtl/mfe_back.sv]
// Back stage: sequences preamble, start, payload and tail bytes into bit cells.
// Depends on mfe_pkg and manchester_frame_encoder_assert.svh.
`default_nettype none

`include "manchester_frame_encoder_assert.svh"

module mfe_back #(
    parameter int PREAMBLE_BYTES = mfe_pkg::PREAMBLE_BYTES_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           job_valid,
    output logic                job_ready,
    input  wire mfe_pkg::desc_t job_desc,
    output logic                cell_valid,
    input  wire logic           cell_ready,
    output logic                cell_first_half,
    output logic                cell_second_half,
    output logic                cell_bit,
    output logic                cell_last
);

    localparam int CNT_W = (PREAMBLE_BYTES > 1) ? $clog2(PREAMBLE_BYTES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PREAMBLE_BYTES - 1);

    logic             busy_reg;
    logic             busy_next;
    mfe_pkg::phase_t  phase_reg;
    mfe_pkg::phase_t  phase_next;
    logic [CNT_W-1:0] byte_cnt_reg;
    logic [CNT_W-1:0] byte_cnt_next;
    logic [2:0]       bit_idx_reg;
    logic [2:0]       bit_idx_next;
    mfe_pkg::desc_t   desc_reg;
    mfe_pkg::desc_t   desc_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_bit_reg;
    logic             out_bit_next;
    logic             out_last_reg;
    logic             out_last_next;

    logic       advance;
    logic       last_cell;
    logic [7:0] cur_byte;
    logic       cur_bit;

    assign advance   = !out_valid_reg || cell_ready;
    assign job_ready = advance && (!busy_reg || last_cell);

    always_comb begin
        unique case (phase_reg)
            mfe_pkg::PH_PREAMBLE: cur_byte = mfe_pkg::SYNC_BYTE;
            mfe_pkg::PH_START:    cur_byte = mfe_pkg::START_BYTE;
            mfe_pkg::PH_DATA:     cur_byte = desc_reg.data;
            mfe_pkg::PH_TAIL:     cur_byte = mfe_pkg::TAIL_BYTE;
            default:              cur_byte = desc_reg.data;
        endcase
    end

    assign cur_bit   = cur_byte[bit_idx_reg];
    assign last_cell = busy_reg && (bit_idx_reg == '0) &&
                       ((phase_reg == mfe_pkg::PH_TAIL) ||
                        (phase_reg == mfe_pkg::PH_DATA && !desc_reg.has_tail));

    always_comb begin
        busy_next      = busy_reg;
        phase_next     = phase_reg;
        byte_cnt_next  = byte_cnt_reg;
        bit_idx_next   = bit_idx_reg;
        desc_next      = desc_reg;
        out_valid_next = out_valid_reg;
        out_bit_next   = out_bit_reg;
        out_last_next  = out_last_reg;

        if (advance) begin
            out_valid_next = busy_reg;
            out_bit_next   = cur_bit;
            out_last_next  = last_cell;
            if (busy_reg) begin
                if (last_cell) begin
                    busy_next    = 1'b0;
                    bit_idx_next = mfe_pkg::MSB_IDX;
                end else if (bit_idx_reg == '0) begin
                    bit_idx_next = mfe_pkg::MSB_IDX;
                    unique case (phase_reg)
                        mfe_pkg::PH_PREAMBLE: begin
                            if (byte_cnt_reg == CNT_LAST) begin
                                phase_next = mfe_pkg::PH_START;
                            end else begin
                                byte_cnt_next = byte_cnt_reg + 1'b1;
                            end
                        end
                        mfe_pkg::PH_START: phase_next = mfe_pkg::PH_DATA;
                        mfe_pkg::PH_DATA:  phase_next = mfe_pkg::PH_TAIL;
                        default:           phase_next = phase_reg;
                    endcase
                end else begin
                    bit_idx_next = bit_idx_reg - 1'b1;
                end
            end
        end

        if (job_valid && job_ready) begin
            busy_next     = 1'b1;
            desc_next     = job_desc;
            phase_next    = job_desc.start_phase;
            byte_cnt_next = '0;
            bit_idx_next  = mfe_pkg::MSB_IDX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            phase_reg     <= mfe_pkg::PH_DATA;
            byte_cnt_reg  <= '0;
            bit_idx_reg   <= mfe_pkg::MSB_IDX;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            byte_cnt_reg  <= byte_cnt_next;
            bit_idx_reg   <= bit_idx_next;
            out_valid_reg <= out_valid_next;
        end
        desc_reg     <= desc_next;
        out_bit_reg  <= out_bit_next;
        out_last_reg <= out_last_next;
    end

    assign cell_valid       = out_valid_reg;
    assign cell_first_half  = out_bit_reg;
    assign cell_second_half = !out_bit_reg;
    assign cell_bit         = out_bit_reg;
    assign cell_last        = out_last_reg;

    `MFE_ASSERT(a_mid_byte_busy, aclk, aresetn, bit_idx_reg != mfe_pkg::MSB_IDX |-> busy_reg)
    `MFE_ASSERT(a_cnt_bound, aclk, aresetn, busy_reg |-> byte_cnt_reg <= CNT_LAST)
    `MFE_ASSERT(a_last_frees, aclk, aresetn,
        advance && last_cell && !job_valid |=> !busy_reg && out_valid_reg && cell_last)

endmodule

`default_nettype wire

[hw/rtl/manchester_frame_encoder.sv]
// Manchester frame encoder top level: front classifier, descriptor queue, bit sequencer.
// Depends on mfe_pkg, mfe_front, mfe_queue and mfe_back.
//
// Input stream: one payload byte per transfer on s_tdata, s_tuser[0] marks the
// first byte of a frame (preamble of PREAMBLE_BYTES x 0xAA and start byte 0xAB
// go out before it), s_tlast marks the last byte (tail byte 0xAF follows it).
// Output stream: one transfer per Manchester bit cell, most significant bit
// first; m_tdata carries the two half-cell levels and the bit, m_tlast marks
// the final cell caused by an input byte.
// Path: an input byte passes the front register, the queue and the sequencer
// before its first cell is registered at the output.
// Throughput: one cell per cycle while the receiver keeps m_tready high; a plain
// byte gives 8 cells, a first byte 8 * (PREAMBLE_BYTES + 2) cells, plus 8 with a
// tail. The bit sequencer emitting one cell a cycle sets this rate; queued bytes
// follow with no gap cycle.
// Reset clears the front register, the queue and the sequencer; no output
// transfer is pending afterwards.
// When the receiver stalls, the output register holds its cell and the queue
// fills; s_tready falls once the queue and front register are both full.
`default_nettype none

module manchester_frame_encoder #(
    parameter int PREAMBLE_BYTES = mfe_pkg::PREAMBLE_BYTES_DEF,
    parameter int QUEUE_DEPTH    = mfe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic [0:0] s_tuser,   // [0] first_of_frame
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [0] first_half_level, [1] second_half_level,
                                       // [2] coded_bit, [7:3] zero
    output logic            m_tlast
);

    logic           fq_valid;
    logic           fq_ready;
    mfe_pkg::desc_t fq_desc;
    logic           qb_valid;
    logic           qb_ready;
    mfe_pkg::desc_t qb_desc;
    logic           cell_first_half;
    logic           cell_second_half;
    logic           cell_bit;

    mfe_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .in_first  (s_tuser[0]),
        .in_last   (s_tlast),
        .out_valid (fq_valid),
        .out_ready (fq_ready),
        .out_desc  (fq_desc)
    );

    mfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_desc  (fq_desc),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_desc   (qb_desc)
    );

    mfe_back #(
        .PREAMBLE_BYTES (PREAMBLE_BYTES)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .job_valid        (qb_valid),
        .job_ready        (qb_ready),
        .job_desc         (qb_desc),
        .cell_valid       (m_tvalid),
        .cell_ready       (m_tready),
        .cell_first_half  (cell_first_half),
        .cell_second_half (cell_second_half),
        .cell_bit         (cell_bit),
        .cell_last        (m_tlast)
    );

    assign m_tdata = {5'b0, cell_bit, cell_second_half, cell_first_half};

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// Testbench for manchester_frame_encoder: streams framed payload bytes in and checks
// every Manchester bit cell against a local frame predictor. Depends on mfe_pkg.
module testbench;

    localparam int         PREAMBLE_COUNT = mfe_pkg::PREAMBLE_BYTES_DEF;
    localparam logic [7:0] SYNC_CODE      = 8'hAA;
    localparam logic [7:0] START_CODE     = 8'hAB;
    localparam logic [7:0] TAIL_CODE      = 8'hAF;
    localparam int         HOLD_AFTER     = 40;
    localparam int         HOLD_CYCLES    = 400;

    typedef struct {
        logic [7:0] data_byte;
        logic       first_of_frame;
        logic       last_of_frame;
    } frame_byte_t;

    typedef struct {
        logic first_half_level;
        logic second_half_level;
        logic coded_bit;
        logic last_of_run;
    } cell_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] data_byte
    logic [0:0] s_tuser = 1'b0;    // [0] first_of_frame
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [0] first_half_level, [1] second_half_level,
                                   // [2] coded_bit, [7:3] zero
    logic       m_tlast;

    frame_byte_t bytes_to_send [$];
    cell_t       cells_due [$];
    frame_byte_t byte_on_bus;
    int          bytes_taken = 0;
    int          cells_seen = 0;
    int          mismatch_count = 0;
    int          tx_gap = 0;
    int          rx_wait = 0;
    int          hold_left = 0;
    logic        hold_started = 1'b0;

    manchester_frame_encoder #(
        .PREAMBLE_BYTES(PREAMBLE_COUNT)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    task automatic predict_cells(input frame_byte_t b);
        logic [7:0] codes [$];
        logic       bitv;
        int         total;
        int         idx;
        if (b.first_of_frame) begin
            for (int k = 0; k < PREAMBLE_COUNT; k++)
                codes.push_back(SYNC_CODE);
            codes.push_back(START_CODE);
        end
        codes.push_back(b.data_byte);
        if (b.last_of_frame)
            codes.push_back(TAIL_CODE);
        total = codes.size() * 8;
        idx = 0;
        foreach (codes[i]) begin
            for (int j = 7; j >= 0; j--) begin
                bitv = codes[i][j];
                cells_due.push_back('{first_half_level: bitv, second_half_level: ~bitv,
                                      coded_bit: bitv, last_of_run: (idx == total - 1)});
                idx++;
            end
        end
    endtask

    task automatic add_byte(input logic [7:0] data, input logic first, input logic last);
        frame_byte_t b;
        b.data_byte = data;
        b.first_of_frame = first;
        b.last_of_frame = last;
        bytes_to_send.push_back(b);
    endtask

    // sender: present the next byte, then idle for a drawn number of cycles
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_cells(byte_on_bus);
                bytes_taken <= bytes_taken + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap != 0) begin
                    tx_gap <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (bytes_to_send.size() > 0) begin
                    byte_on_bus = bytes_to_send.pop_front();
                    s_tdata <= byte_on_bus.data_byte;
                    s_tuser <= byte_on_bus.first_of_frame;
                    s_tlast <= byte_on_bus.last_of_frame;
                    s_tvalid <= 1'b1;
                    tx_gap <= (bytes_taken % 100 < 25) ? 0 : $urandom_range(0, 15);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the input side backs up
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (!hold_started && bytes_taken >= HOLD_AFTER) begin
            hold_started <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver: check each cell transfer, then drop ready for a drawn number of cycles
    always @(posedge aclk) begin
        cell_t exp_cell;
        logic [7:0] exp_tdata;
        int w;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                cells_seen <= cells_seen + 1;
                if (cells_due.size() == 0) begin
                    $display("%0t ns: unexpected cell, expected none, got tdata %02h tlast %0b",
                             $time, m_tdata, m_tlast);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    exp_cell = cells_due.pop_front();
                    exp_tdata = {5'b00000, exp_cell.coded_bit, exp_cell.second_half_level,
                                 exp_cell.first_half_level};
                    if (m_tdata !== exp_tdata || m_tlast !== exp_cell.last_of_run) begin
                        $display("%0t ns: expected tdata %02h tlast %0b, got %02h tlast %0b",
                                 $time, exp_tdata, exp_cell.last_of_run, m_tdata, m_tlast);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
                w = (cells_seen % 400 < 100) ? 0 : $urandom_range(0, 15);
            end else if (rx_wait != 0) begin
                w = rx_wait - 1;
            end else begin
                w = 0;
            end
            rx_wait <= w;
            m_tready <= (w == 0) && (hold_left == 0);
        end
    end

    initial begin
        int len;
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'h80, 1'b0, 1'b0);
        add_byte(8'h01, 1'b0, 1'b0);
        add_byte(8'h55, 1'b1, 1'b0);
        add_byte(8'hAA, 1'b0, 1'b0);
        add_byte(8'h7E, 1'b0, 1'b1);
        add_byte(8'hFF, 1'b1, 1'b1);
        add_byte(8'h00, 1'b1, 1'b1);
        // flags out of frame order
        add_byte(8'hC3, 1'b0, 1'b1);
        add_byte(8'h3C, 1'b0, 1'b1);
        add_byte(8'hA5, 1'b1, 1'b0);
        add_byte(8'h5A, 1'b1, 1'b0);
        add_byte(8'hAB, 1'b0, 1'b0);
        add_byte(8'hAF, 1'b0, 1'b0);
        add_byte(8'h81, 1'b1, 1'b1);
        while (bytes_to_send.size() < 416) begin
            if ($urandom_range(0, 4) != 0) begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    add_byte(8'($urandom_range(0, 255)), i == 0, i == len - 1);
            end else begin
                add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (bytes_to_send.size() != 0 || s_tvalid || cells_due.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);

        if (mismatch_count == 0) begin
            $display("manchester_frame_encoder: match");
        end else begin
            $display("manchester_frame_encoder: mismatch");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("manchester_frame_encoder: mismatch");
        $finish;
    end

endmodule
